// ----- rtl/text_console_writer_defines.svh -----
// assertion helpers used by the checker file
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define TCW_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define TCW_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `TCW_ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

   // default screen geometry
   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;

   // field widths
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int CADDR_W    = 11;
   localparam int CELL_W     = 16;
   localparam int ROW_OUT_W  = 5;
   localparam int COL_OUT_W  = 7;
   localparam int COLOR_W    = 8;

   // packed stream words
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_ROW_LSB = CELL_W;
   localparam int RSP_COL_LSB = CELL_W + ROW_OUT_W;

   // commands
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // special characters
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // a tab puts this many spaces
   localparam int TAB_SPACES = 4;

   // configuration registers
   localparam int                 CSR_ADDR_W      = 3;
   localparam int                 CSR_DATA_W      = 32;
   localparam logic [CSR_ADDR_W-1:0] TEXT_COLOR_ADDR = 3'd0;
   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

   // cell contents after reset
   localparam logic [CELL_W-1:0] RESET_CELL = {TEXT_COLOR_RESET, CHAR_SPACE};

endpackage

// ----- rtl/text_console_writer.sv -----
// Text console: a SCREEN_ROWS x SCREEN_COLUMNS screen of 16-bit cells (character in the low
// byte, attribute in the high byte) held in one single-port-write, single-port-read memory,
// plus a cursor. A word on the request stream carries a command in tuser: put character, read
// cell, or clear screen and home; every command gives exactly one response word with the read
// cell (zero unless a read) and the cursor after the command. All cell writes go through
// the one memory write port, and each wrap past the last row adds a scroll (row copy one
// cell a cycle, then the bottom row blanked). After reset the block first writes every cell
// to a space with attribute 0x07, with req_tready low; the text_color register can be
// written meanwhile. One command is in work at a time; the next is taken while a response
// still waits.
module text_console_writer #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_code [7:0], cell_address [18:8], zero [23:19]
   input  logic [tcw_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [tcw_pkg::CMD_W-1:0]       req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cell_value [15:0], cursor_row [20:16], cursor_column [27:21], zero [31:28]
   output logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int RW         = $clog2(SCREEN_ROWS);
   localparam int CW         = $clog2(SCREEN_COLUMNS);

   localparam logic [RW-1:0] LAST_ROW      = RW'(SCREEN_ROWS - 1);
   localparam logic [CW-1:0] LAST_COL      = CW'(SCREEN_COLUMNS - 1);
   localparam logic [AW-1:0] LAST_CELL     = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] LAST_COPY     = AW'(CELL_COUNT - SCREEN_COLUMNS - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
   localparam logic [AW-1:0] ROW_STEP      = AW'(SCREEN_COLUMNS);

   // sequencer states
   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PUT    = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_BLANK  = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam logic [1:0] TAB_REST = 2'(TAB_SPACES - 1);

   logic [2:0]         state_ff, state_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [1:0]         rep_ff, rep_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               copy_pend_ff, copy_pend_in;
   logic [AW-1:0]      copy_addr_ff, copy_addr_in;
   logic               addr_ok_ff, addr_ok_in;
   logic [CELL_W-1:0]  value_ff, value_in;
   logic [COLOR_W-1:0] text_color_ff, text_color_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;

   logic               req_accept;
   logic [CMD_W-1:0]   req_cmd;
   logic [CHAR_W-1:0]  req_char;
   logic [CADDR_W-1:0] req_addr;
   logic               req_addr_ok;
   logic               csr_write;

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [CELL_W-1:0]  mem_wr_data;
   logic [AW-1:0]      mem_rd_addr;
   logic [CELL_W-1:0]  mem_rd_data;
   logic [CELL_W-1:0]  blank_cell;
   logic [AW-1:0]      cursor_addr;
   logic [AW-1:0]      next_base;

   // unpack request word
   assign req_cmd     = req_tuser;
   assign req_char    = req_tdata[CHAR_W-1:0];
   assign req_addr    = req_tdata[CHAR_W +: CADDR_W];
   assign req_addr_ok = 32'(req_addr) < 32'(CELL_COUNT);
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;

   // address arithmetic
   assign blank_cell  = {text_color_ff, CHAR_SPACE};
   assign cursor_addr = base_ff + AW'(col_ff);
   assign next_base   = base_ff + ROW_STEP;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == TEXT_COLOR_ADDR);
   assign csr_prdata = (csr_paddr == TEXT_COLOR_ADDR) ?
                       CSR_DATA_W'(text_color_ff) : '0;
   assign text_color_in = csr_write ? csr_pwdata[COLOR_W-1:0] : text_color_ff;

   // cell memory
   tcw_cell_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      rep_in       = rep_ff;
      char_in      = char_ff;
      copy_pend_in = 1'b0;
      copy_addr_in = copy_addr_ff;
      addr_ok_in   = addr_ok_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ptr_ff;
      mem_wr_data  = blank_cell;
      mem_rd_addr  = req_addr_ok ? AW'(req_addr) : '0;

      case (state_ff)
         // reset clearing pass
         ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = RESET_CELL;
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // decode a new command
         ST_IDLE: begin
            if (req_accept) begin
               value_in   = '0;
               char_in    = req_char;
               rep_in     = '0;
               addr_ok_in = req_addr_ok;
               case (req_cmd)
                  CMD_PUT: begin
                     if (req_char == CHAR_NUL) begin
                        state_in = ST_DONE;
                     end else if (req_char == CHAR_NL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           ptr_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in   = row_ff + 1'b1;
                           base_in  = next_base;
                           state_in = ST_DONE;
                        end
                     end else if (req_char == CHAR_TAB) begin
                        char_in  = CHAR_SPACE;
                        rep_in   = TAB_REST;
                        state_in = ST_PUT;
                     end else begin
                        state_in = ST_PUT;
                     end
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  CMD_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     base_in  = '0;
                     ptr_in   = '0;
                     state_in = ST_BLANK;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // write one character and advance the cursor
         ST_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cursor_addr;
            mem_wr_data = {text_color_ff, char_ff};
            if ((col_ff == LAST_COL) && (row_ff == LAST_ROW)) begin
               col_in   = '0;
               ptr_in   = '0;
               state_in = ST_SCROLL;
            end else begin
               if (col_ff == LAST_COL) begin
                  col_in  = '0;
                  row_in  = row_ff + 1'b1;
                  base_in = next_base;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (rep_ff != '0) begin
                  rep_in = rep_ff - 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // copy each cell one row up, read and write overlapped
         ST_SCROLL: begin
            mem_rd_addr  = ptr_ff + ROW_STEP;
            copy_pend_in = 1'b1;
            copy_addr_in = ptr_ff;
            if (copy_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = copy_addr_ff;
               mem_wr_data = mem_rd_data;
            end
            if (ptr_ff == LAST_COPY) begin
               ptr_in   = LAST_ROW_BASE;
               state_in = ST_BLANK;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // blank cells from ptr to the end, after the last copy lands
         ST_BLANK: begin
            mem_wr_en = 1'b1;
            if (copy_pend_ff) begin
               mem_wr_addr = copy_addr_ff;
               mem_wr_data = mem_rd_data;
            end else if (ptr_ff == LAST_CELL) begin
               ptr_in = '0;
               if (rep_ff != '0) begin
                  rep_in   = rep_ff - 1'b1;
                  state_in = ST_PUT;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // read data is back
         ST_READ: begin
            value_in = addr_ok_ff ? mem_rd_data : '0;
            state_in = ST_DONE;
         end

         // hand the word to the response register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_row_in   = ROW_OUT_W'(row_ff);
               rsp_col_in   = COL_OUT_W'(col_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         base_ff       <= '0;
         ptr_ff        <= '0;
         rep_ff        <= '0;
         copy_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         text_color_ff <= TEXT_COLOR_RESET;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         base_ff       <= base_in;
         ptr_ff        <= ptr_in;
         rep_ff        <= rep_in;
         copy_pend_ff  <= copy_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         text_color_ff <= text_color_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      copy_addr_ff <= copy_addr_in;
      addr_ok_ff   <= addr_ok_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   // pack response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_col_ff, rsp_row_ff, rsp_value_ff});

endmodule

// ----- rtl/tcw_cell_ram.sv -----
module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tcw_checker.sv -----
`include "text_console_writer_defines.svh"

module tcw_checker #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            csr_pready
);
   import tcw_pkg::*;

   // a stalled response word holds
   `TCW_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // one command at a time: busy right after a word is taken
   `TCW_ASSERT_CLK(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while a command is in work")

   // register port never waits
   `TCW_ASSERT_NEVER(a_pready_high, clock, reset, !csr_pready, "register port not ready")

   // reported cursor stays on the screen
   `TCW_ASSERT_NEVER(a_col_range, clock, reset, rsp_tvalid && (32'(rsp_tdata[RSP_COL_LSB +: COL_OUT_W]) >= 32'(SCREEN_COLUMNS)), "cursor column off screen")

   `TCW_ASSERT_NEVER(a_row_range, clock, reset, rsp_tvalid && (32'(rsp_tdata[RSP_ROW_LSB +: ROW_OUT_W]) >= 32'(SCREEN_ROWS)), "cursor row off screen")

endmodule

bind text_console_writer tcw_checker #(
   .SCREEN_COLUMNS (SCREEN_COLUMNS),
   .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (.*);

// ----- sim/tb_top.sv -----
module tb_top;
   import tcw_pkg::*;

   // screen geometry used by the block instance
   localparam int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS;
   localparam int SCREEN_ROWS    = DEF_SCREEN_ROWS;
   localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;

   // command code the block does not use
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int PHASES           = 5;
   localparam int WORDS_PER_PHASE  = 350;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 20;
   localparam int CYCLE_LIMIT      = 20_000_000;

   // one response word split into its fields
   typedef struct {
      logic [CELL_W-1:0]    value;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
   } cursor_report_type;

   // shadow copy of the screen and cursor, plus the reports still owed by the block
   class shadow_screen;
      logic [CELL_W-1:0]  cells [SCREEN_CELLS];
      int                 row_pos;
      int                 col_pos;
      logic [COLOR_W-1:0] text_color;
      cursor_report_type  owed_reports [$];
      int errors  = 0;
      int puts    = 0;
      int reads   = 0;
      int clears  = 0;
      int unused  = 0;
      int scrolls = 0;

      function new();
         text_color = TEXT_COLOR_RESET;
         row_pos    = 0;
         col_pos    = 0;
         blank_from(0);
      endfunction

      function void blank_from(int first_row);
         for (int i = first_row * SCREEN_COLUMNS; i < SCREEN_CELLS; i++)
            cells[i] = {text_color, CHAR_SPACE};
      endfunction

      function void scroll_up();
         for (int i = 0; i + SCREEN_COLUMNS < SCREEN_CELLS; i++)
            cells[i] = cells[i + SCREEN_COLUMNS];
         blank_from(SCREEN_ROWS - 1);
         scrolls++;
      endfunction

      // wrap at the end of a row, scroll past the last row
      function void settle_cursor();
         if (col_pos >= SCREEN_COLUMNS) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= SCREEN_ROWS) begin
            row_pos = SCREEN_ROWS - 1;
            scroll_up();
         end
      endfunction

      function void put_plain(logic [CHAR_W-1:0] ch);
         cells[row_pos * SCREEN_COLUMNS + col_pos] = {text_color, ch};
         col_pos++;
         settle_cursor();
      endfunction

      function void put_char(logic [CHAR_W-1:0] ch);
         if (ch == CHAR_NUL)
            return;
         if (ch == CHAR_NL) begin
            col_pos = 0;
            row_pos++;
            settle_cursor();
         end else if (ch == CHAR_TAB) begin
            for (int k = 0; k < TAB_SPACES; k++)
               put_plain(CHAR_SPACE);
         end else begin
            put_plain(ch);
         end
      endfunction

      // apply an accepted command and queue the report it owes
      function void take_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                 logic [CADDR_W-1:0] addr);
         cursor_report_type rep;
         rep.value = '0;
         case (cmd)
            CMD_PUT: begin
               puts++;
               put_char(ch);
            end
            CMD_READ: begin
               reads++;
               if (addr < SCREEN_CELLS)
                  rep.value = cells[addr];
            end
            CMD_CLEAR: begin
               clears++;
               blank_from(0);
               row_pos = 0;
               col_pos = 0;
            end
            default: begin
               unused++;
            end
         endcase
         rep.row = ROW_OUT_W'(row_pos);
         rep.col = COL_OUT_W'(col_pos);
         owed_reports.push_back(rep);
      endfunction

      // compare one response word with the oldest owed report
      function void match_report(logic [RSP_TDATA_W-1:0] word);
         cursor_report_type want;
         cursor_report_type got;
         got.value = word[CELL_W-1:0];
         got.row   = word[RSP_ROW_LSB +: ROW_OUT_W];
         got.col   = word[RSP_COL_LSB +: COL_OUT_W];
         if (owed_reports.size() == 0) begin
            $display("%0t: response word %h arrived with nothing owed", $time, word);
            errors++;
            return;
         end
         want = owed_reports.pop_front();
         if (got.value !== want.value) begin
            $display("%0t: cell_value expected %h got %h", $time, want.value, got.value);
            errors++;
         end
         if (got.row !== want.row) begin
            $display("%0t: cursor_row expected %0d got %0d", $time, want.row, got.row);
            errors++;
         end
         if (got.col !== want.col) begin
            $display("%0t: cursor_column expected %0d got %0d", $time, want.col, got.col);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // char_code [7:0], cell_address [18:8], zero [23:19]
   logic [REQ_TDATA_W-1:0] req_tdata;
   // cmd [1:0]
   logic [CMD_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // cell_value [15:0], cursor_row [20:16], cursor_column [27:21], zero [31:28]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   shadow_screen screen;
   bit           hold_request = 1'b0;
   bit           no_idle = 1'b0;
   int           cycle_count = 0;
   int           color_writes = 0;

   text_console_writer #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one request word and wait for it to be taken
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic [CADDR_W-1:0] addr);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W - CADDR_W - CHAR_W){1'b0}}, addr, ch};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      screen.take_command(cmd, ch, addr);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one register transfer: setup phase, then access until pready
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write text_color and read it back
   task automatic set_text_color(input logic [COLOR_W-1:0] color);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, TEXT_COLOR_ADDR, CSR_DATA_W'(color), rd);
      screen.text_color = color;
      color_writes++;
      @(posedge clock);
      csr_access(1'b0, TEXT_COLOR_ADDR, '0, rd);
      if (rd[COLOR_W-1:0] !== color) begin
         $display("%0t: text_color read expected %h got %h", $time, color, rd[COLOR_W-1:0]);
         screen.errors++;
      end
   endtask

   // random command: mostly text with newlines and tabs, reads often near the cursor
   task automatic make_random_request(output logic [CMD_W-1:0] cmd,
                                      output logic [CHAR_W-1:0] ch,
                                      output logic [CADDR_W-1:0] addr);
      int r;
      int s;
      int near;
      r    = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom_range(0, 255));
      addr = CADDR_W'($urandom_range(0, 2047));
      if ($urandom_range(0, 249) == 0) begin
         cmd = CMD_CLEAR;
      end else if (r < 72) begin
         cmd = CMD_PUT;
         s = $urandom_range(0, 99);
         if (s < 65)
            ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
         else if (s < 85)
            ch = CHAR_NL;
         else if (s < 91)
            ch = CHAR_TAB;
         else if (s < 94)
            ch = CHAR_NUL;
      end else if (r < 92) begin
         cmd = CMD_READ;
         s = $urandom_range(0, 9);
         if (s < 5) begin
            near = screen.row_pos * SCREEN_COLUMNS + screen.col_pos
                   - int'($urandom_range(0, 8));
            if (near < 0)
               near = 0;
            addr = CADDR_W'(near);
         end else if (s < 9) begin
            addr = CADDR_W'($urandom_range(0, SCREEN_CELLS - 1));
         end
      end else begin
         cmd = CMD_UNUSED;
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            screen.match_report(rsp_tdata);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = no_idle ? 0 : pick_gap();
         end
      end
   end

   // request side and phase control
   initial begin
      logic [CMD_W-1:0]   cmd;
      logic [CHAR_W-1:0]  ch;
      logic [CADDR_W-1:0] addr;
      screen = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_PUT;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, range edges of reads, special characters
      send_request(CMD_READ, CHAR_NUL, 11'd0);
      send_request(CMD_READ, 8'hff, 11'(SCREEN_CELLS - 1));
      send_request(CMD_READ, CHAR_NUL, 11'(SCREEN_CELLS));
      send_request(CMD_READ, CHAR_NUL, 11'h7ff);
      send_request(CMD_PUT, 8'h41, 11'd0);
      send_request(CMD_PUT, 8'hff, 11'h7ff);
      send_request(CMD_PUT, 8'h80, 11'h400);
      send_request(CMD_PUT, CHAR_NUL, 11'd0);
      send_request(CMD_PUT, CHAR_TAB, 11'd0);
      send_request(CMD_PUT, CHAR_NL, 11'd0);
      send_request(CMD_UNUSED, 8'hff, 11'h7ff);
      send_request(CMD_READ, CHAR_NUL, 11'd1);
      send_request(CMD_READ, CHAR_NUL, 11'd5);
      send_request(CMD_PUT, 8'h01, 11'd0);
      send_request(CMD_READ, CHAR_NUL, 11'(SCREEN_COLUMNS));
      send_request(CMD_UNUSED, CHAR_NUL, 11'd0);
      send_request(CMD_CLEAR, 8'h55, 11'h2aa);
      send_request(CMD_READ, CHAR_NUL, 11'd0);
      send_request(CMD_READ, CHAR_NUL, 11'(SCREEN_COLUMNS + 1));

      // random phases, each under its own text color
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            req_tvalid <= 1'b0;
            while (screen.owed_reports.size() != 0)
               @(posedge clock);
            case (phase)
               1: set_text_color(8'h00);
               2: set_text_color(8'hff);
               default: set_text_color(COLOR_W'($urandom_range(0, 255)));
            endcase
            @(posedge clock);
         end
         if (phase == 2)
            hold_request = 1'b1;
         no_idle = (phase == 3);
         repeat (WORDS_PER_PHASE) begin
            make_random_request(cmd, ch, addr);
            send_request(cmd, ch, addr);
         end
      end
      req_tvalid <= 1'b0;

      // drain
      while (screen.owed_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: ran %0d puts, %0d reads, %0d clears and %0d unused commands",
               screen.puts, screen.reads, screen.clears, screen.unused);
      $display("tb: the screen scrolled %0d times under %0d text color settings",
               screen.scrolls, color_writes + 1);
      if (screen.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
